FILE: rtl/bmalloc_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap allocator package
// Shared types and constants for the first-free bitmap allocator.
// ----------------------------------------------------------------------------
package bmalloc_pkg;

    // Fixed field widths of the item interface and the size register.
    localparam int SLOT_W = 10;
    localparam int SIZE_W = 11;

    // Wide enough for a running slot base one word past the largest size.
    localparam int BASE_W = 12;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

    typedef enum logic [1:0] {
        FUNC_SET    = 2'd0,
        FUNC_CLEAR  = 2'd1,
        FUNC_SEARCH = 2'd2,
        FUNC_INIT   = 2'd3
    } t_func;

    typedef struct packed {
        t_func              func;
        logic [SLOT_W-1:0]  slot_index;
    } t_in_item;

    typedef struct packed {
        logic               found;
        logic [SLOT_W-1:0]  first_free;
        logic               out_of_range;
    } t_out_item;

endpackage

FILE: rtl/bmalloc_ram.sv
// ----------------------------------------------------------------------------
// Bitmap allocator word store
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module bmalloc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                          i_clk,
    input  logic                                          i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_waddr,
    input  logic [WIDTH-1:0]                              i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_raddr,
    output logic [WIDTH-1:0]                              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/bitmap_allocator_first_free_top.sv
// ----------------------------------------------------------------------------
// Bitmap allocator with first-free search
// Keeps a used/free bitmap in a word RAM and serves set, clear, search and
// init requests one at a time through a small sequencer.
// ----------------------------------------------------------------------------
// Each request yields exactly one result transfer. Set and clear pass through
// a reciprocal multiply that finds the word, then a read-modify-write of that
// word through the registered RAM port; an index outside the managed size
// skips the RAM and is answered out of range. Search reads the words in use
// one per cycle from the single RAM read port and stops at the first word with
// a free bit, answering not found when no word in use has one. Init writes one
// word per cycle. The RAM port therefore sets the rate of the long operations.
// A result that still waits in the output register holds the next finished
// result back for as long as it waits. After reset the block clears the RAM
// word by word, during which input transfers are stalled; size writes are
// taken at any time. A finished result sits in an output register, so the
// next request may be accepted while the previous result still waits to be
// taken.
// ----------------------------------------------------------------------------
module bitmap_allocator_first_free_top
    import bmalloc_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int NUM_WORDS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Size register write port.
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_wdata,
    // Request channel.
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_data,
    // Result channel.
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_data
);

    // Address and bit position widths follow from the bitmap geometry.
    localparam int AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BW = $clog2(WORD_BITS);

    // Capacity in slots, clamped to what the size register can express.
    localparam int CAP = NUM_WORDS * WORD_BITS;
    localparam logic [SIZE_W-1:0] CAP_CLAMP =
        SIZE_W'((CAP > 2047) ? 2047 : CAP);

    // Reciprocal for slot_index / WORD_BITS: exact for every 10-bit index
    // because the shift carries BW bits of headroom beyond the index width.
    localparam int RSHIFT = SLOT_W + BW;
    localparam int RECIP = ((1 << RSHIFT) + WORD_BITS - 1) / WORD_BITS;
    localparam logic [RSHIFT-1:0] RECIP_C = RSHIFT'(RECIP);
    localparam logic [SLOT_W-1:0] WORD_C = SLOT_W'(WORD_BITS);
    localparam logic [BASE_W-1:0] STEP_C = BASE_W'(WORD_BITS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_WORDS - 1);

    typedef enum logic [7:0] {
        S_CLR  = 8'b0000_0001,
        S_IDLE = 8'b0000_0010,
        S_DIV  = 8'b0000_0100,
        S_RD   = 8'b0000_1000,
        S_WR   = 8'b0001_0000,
        S_SRCH = 8'b0010_0000,
        S_INIT = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    // Control registers.
    t_state            r_state, n_state;
    logic [SIZE_W-1:0] r_size;
    logic              r_out_valid, n_out_valid;
    logic              r_pv, n_pv;

    // Working registers.
    t_func             r_func, n_func;
    logic [SLOT_W-1:0] r_idx, n_idx;
    logic [SLOT_W-1:0] r_q, n_q;
    logic [BW-1:0]     r_bitpos, n_bitpos;
    logic [AW-1:0]     r_addr, n_addr;
    logic [BASE_W-1:0] r_base, n_base;
    logic [BASE_W-1:0] r_pbase, n_pbase;
    t_out_item         r_res, n_res;
    t_out_item         r_out, n_out;

    // RAM port signals.
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    // Datapath signals.
    logic [SIZE_W-1:0]      slots_n;
    logic [BASE_W-1:0]      slots_n_ext;
    logic                   in_accept;
    logic                   out_free;
    logic [SLOT_W+RSHIFT-1:0] recip_prod;
    logic [2*SLOT_W-1:0]    word_prod;
    logic [SLOT_W-1:0]      bit_diff;
    logic [WORD_BITS-1:0]   bit_mask;
    logic [BASE_W-1:0]      tail_base;
    logic [BASE_W-1:0]      tail_rem;
    logic [WORD_BITS-1:0]   tail_mask;
    logic [WORD_BITS-1:0]   free_bits;
    logic [WORD_BITS-1:0]   lowest_free;
    logic [BW-1:0]          free_pos;
    logic [BASE_W-1:0]      free_slot;
    logic                   issue_more;
    logic                   idx_in_range;

    bmalloc_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Slots actually managed: the size register bounded by the capacity.
    assign slots_n     = (r_size > CAP_CLAMP) ? CAP_CLAMP : r_size;
    assign slots_n_ext = BASE_W'(slots_n);

    assign in_accept = i_in_valid && (r_state == S_IDLE);
    assign out_free  = !r_out_valid || !i_out_stall;

    // Word and bit of the requested slot.
    assign recip_prod   = r_idx * RECIP_C;
    assign word_prod    = r_q * WORD_C;
    assign bit_diff     = r_idx - word_prod[SLOT_W-1:0];
    assign idx_in_range = {1'b0, r_idx} < slots_n;

    always_comb begin
        bit_mask = '0;
        bit_mask[r_bitpos] = 1'b1;
    end

    // Shared tail unit: every bit at or past the managed size reads as used.
    // Search feeds it the base of the word coming back from the RAM, init the
    // base of the word being written.
    assign tail_base = (r_state == S_SRCH) ? r_pbase : r_base;
    assign tail_rem  = slots_n_ext - tail_base;

    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            tail_mask[b] = (BASE_W'(b) >= tail_rem);
        end
    end

    // Lowest free bit of the returned word, isolated and encoded.
    assign free_bits   = ~(ram_rdata | tail_mask);
    assign lowest_free = free_bits & (~free_bits + WORD_BITS'(1));

    always_comb begin
        free_pos = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            if (lowest_free[b]) begin
                free_pos = free_pos | BW'(b);
            end
        end
    end

    assign free_slot  = r_pbase + BASE_W'(free_pos);
    assign issue_more = r_base < slots_n_ext;

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_pv        = 1'b0;
        n_func      = r_func;
        n_idx       = r_idx;
        n_q         = r_q;
        n_bitpos    = r_bitpos;
        n_addr      = r_addr;
        n_base      = r_base;
        n_pbase     = r_pbase;
        n_res       = r_res;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_waddr   = r_addr;
        ram_wdata   = '0;
        ram_raddr   = r_addr;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLR: begin
                ram_we = 1'b1;
                if (r_addr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    n_func = i_in_data.func;
                    n_idx  = i_in_data.slot_index;
                    n_addr = '0;
                    n_base = '0;
                    unique case (i_in_data.func)
                        FUNC_SET, FUNC_CLEAR: n_state = S_DIV;
                        FUNC_SEARCH:          n_state = S_SRCH;
                        FUNC_INIT:            n_state = S_INIT;
                        default:              n_state = S_IDLE;
                    endcase
                end
            end
            S_DIV: begin
                n_q = recip_prod[RSHIFT +: SLOT_W];
                if (idx_in_range) begin
                    n_state = S_RD;
                end else begin
                    n_res   = '{found: 1'b0, first_free: '0, out_of_range: 1'b1};
                    n_state = S_DONE;
                end
            end
            S_RD: begin
                ram_raddr = AW'(r_q);
                n_bitpos  = bit_diff[BW-1:0];
                n_state   = S_WR;
            end
            S_WR: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(r_q);
                if (r_func == FUNC_SET) begin
                    ram_wdata = ram_rdata | bit_mask;
                end else begin
                    ram_wdata = ram_rdata & ~bit_mask;
                end
                n_res   = '0;
                n_state = S_DONE;
            end
            S_SRCH: begin
                if (issue_more) begin
                    n_addr = r_addr + AW'(1);
                    n_base = r_base + STEP_C;
                end
                n_pv    = issue_more;
                n_pbase = r_base;
                if (r_pv && (free_bits != '0)) begin
                    n_res   = '{found: 1'b1, first_free: free_slot[SLOT_W-1:0],
                                out_of_range: 1'b0};
                    n_state = S_DONE;
                end else if (!r_pv && !issue_more) begin
                    n_res   = '0;
                    n_state = S_DONE;
                end
            end
            S_INIT: begin
                if (issue_more) begin
                    ram_we    = 1'b1;
                    ram_wdata = tail_mask;
                    n_addr    = r_addr + AW'(1);
                    n_base    = r_base + STEP_C;
                end else begin
                    n_res   = '0;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_size      <= SIZE_RESET;
            r_out_valid <= 1'b0;
            r_pv        <= 1'b0;
            r_addr      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_pv        <= n_pv;
            r_addr      <= n_addr;
            if (i_cfg_we) begin
                r_size <= i_cfg_wdata;
            end
        end
    end

    // Payload and working registers.
    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_idx    <= n_idx;
        r_q      <= n_q;
        r_bitpos <= n_bitpos;
        r_base   <= n_base;
        r_pbase  <= n_pbase;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTH
    // An accepted request keeps the input side stalled in the next cycle.
    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_in_stall
    ) else $error("input not stalled after a request was accepted");

    // Search results and range flags never appear together.
    a_flags_exclusive: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.found && o_out_data.out_of_range)
    ) else $error("found and out_of_range both set");

    // A slot reported free always lies inside the managed size.
    a_found_in_range: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.found) |-> ({1'b0, o_out_data.first_free} < slots_n)
    ) else $error("reported free slot lies outside the managed size");

    // A new result is only ever loaded from the completion state.
    a_result_from_done: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE)
    ) else $error("result offered without the sequencer completing");
`endif

endmodule
